### hw/rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition implies consequence in the same cycle
`define ASSERT_IMPLIES(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error("assertion failed");

// condition implies consequence in the next cycle
`define ASSERT_NEXT(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error("assertion failed");

`endif

### hw/rtl/lj_pkg.sv
`default_nettype none
package lj_pkg;

   localparam int WORD_W = 63;
   typedef logic signed [WORD_W-1:0] word_type;

   localparam logic [61:0] MAG_MAX = {62{1'b1}};
   localparam word_type SAT_MAX = {1'b0, MAG_MAX};

   localparam int MUL_LAT = 3;
   localparam int DIV_STEP_DEF = 4;

   localparam int REQ_W = 168;
   localparam int RSP_W = 240;
   localparam int CSR_AW = 4;
   localparam int OUT_W = 48;

   localparam int INV_NUM_W = 49;
   localparam int RR_W = 23;
   localparam int DISP_NUM_W = 26;
   localparam int DISP_DEN_W = 24;

   localparam logic [1:0] REG_CUTOFF_RADIUS = 2'd0;
   localparam logic [1:0] REG_CELL_LENGTH = 2'd1;
   localparam logic [1:0] REG_CUTOFF_ENERGY = 2'd2;
   localparam logic [1:0] REG_SHIFT_SLOPE = 2'd3;

   localparam logic [22:0] CUTOFF_RESET = 23'd0;
   localparam logic [22:0] LENGTH_RESET = 23'd655360;

   localparam logic signed [7:0] SCALE_48 = 8'sd48;
   localparam logic signed [7:0] SCALE_24 = 8'sd24;
   localparam logic signed [7:0] SCALE_4 = 8'sd4;

   localparam logic [54:0] OUT_POS_MAX = 55'h7FFF_FFFF_FFFF;
   localparam logic [54:0] OUT_NEG_MAX = 55'h8000_0000_0000;

   function automatic word_type sat_add(word_type a, word_type b);
      logic signed [63:0] s;
      s = 64'(a) + 64'(b);
      if (s > 64'(SAT_MAX)) begin
         return SAT_MAX;
      end else if (s < -64'(SAT_MAX)) begin
         return -SAT_MAX;
      end
      return s[62:0];
   endfunction

   function automatic word_type sat_scale(word_type x, logic signed [7:0] k);
      logic signed [70:0] p;
      p = 71'(x) * 71'(k);
      if (p > 71'(SAT_MAX)) begin
         return SAT_MAX;
      end else if (p < -71'(SAT_MAX)) begin
         return -SAT_MAX;
      end
      return p[62:0];
   endfunction

   function automatic logic signed [OUT_W-1:0] to_out(word_type q);
      logic [62:0] m;
      logic [54:0] sh;
      m = q[62] ? 63'(-q) : 63'(q);
      sh = m[62:8];
      if (q[62]) begin
         if (sh > OUT_NEG_MAX) begin
            return OUT_NEG_MAX[47:0];
         end
         return 48'(-sh);
      end
      if (sh > OUT_POS_MAX) begin
         return OUT_POS_MAX[47:0];
      end
      return sh[47:0];
   endfunction

endpackage
`default_nettype wire

### hw/rtl/lj_pair_force_energy.sv
// channel  | dir | ports                        | contents
// req      | in  | req_tvalid/tready/tdata      | two positions and pair distance
// rsp      | out | rsp_tvalid/tready/tdata/tuser| forces, virial, energy, in-range flag
// csr      | in  | csr_psel..csr_pready         | cutoff, cell length, energy, slope
//
// fully pipelined: one request per cycle while the output is not stalled; the chain of
// seven 3-stage multipliers sets most of the pipeline depth, the reciprocal divider,
// one stage per DIV_STEP quotient bits, most of the rest
// synchronous reset clears valid bits and delay taps and sets the configuration registers to their reset values
// a stalled output freezes the whole pipeline; nothing is dropped or repeated
`default_nettype none
module lj_pair_force_energy #(
   parameter int DIV_STEP = lj_pkg::DIV_STEP_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // first_x, first_y, first_z, second_x, second_y, second_z, pair_distance, pad
   input  logic [lj_pkg::REQ_W-1:0]  req_tdata,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // force_x, force_y, force_z, virial_term, pair_energy
   output logic [lj_pkg::RSP_W-1:0]  rsp_tdata,
   // in_range
   output logic [0:0]                rsp_tuser,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [lj_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [31:0]               csr_pwdata,
   output logic [31:0]               csr_prdata,
   output logic                      csr_pready
);
   import lj_pkg::*;

   localparam int LI = (INV_NUM_W + DIV_STEP - 1) / DIV_STEP;
   localparam int LD = (DISP_NUM_W + DIV_STEP - 1) / DIV_STEP;
   localparam int ML = MUL_LAT;
   localparam logic [INV_NUM_W-1:0] INV_NUM = {1'b1, {(INV_NUM_W-1){1'b0}}};

   // configuration
   logic [22:0] cutoff_ff, length_ff;
   logic signed [31:0] energy_ff, slope_ff;
   logic csr_we;
   logic [22:0] len_fix;
   logic active;
   word_type slope_q, ce_q;

   assign csr_pready = 1'b1;
   assign csr_we = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cutoff_ff <= CUTOFF_RESET;
         length_ff <= LENGTH_RESET;
         energy_ff <= '0;
         slope_ff <= '0;
      end else if (csr_we) begin
         case (csr_paddr[3:2])
            REG_CUTOFF_RADIUS: cutoff_ff <= csr_pwdata[22:0];
            REG_CELL_LENGTH:   length_ff <= csr_pwdata[22:0];
            REG_CUTOFF_ENERGY: energy_ff <= csr_pwdata;
            REG_SHIFT_SLOPE:   slope_ff <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_CUTOFF_RADIUS: csr_prdata = {9'b0, cutoff_ff};
         REG_CELL_LENGTH:   csr_prdata = {9'b0, length_ff};
         REG_CUTOFF_ENERGY: csr_prdata = energy_ff;
         REG_SHIFT_SLOPE:   csr_prdata = slope_ff;
         default:           csr_prdata = '0;
      endcase
   end

   assign len_fix = (length_ff == '0) ? 23'd1 : length_ff;
   assign active = cutoff_ff != '0;
   assign slope_q = 63'(slope_ff) <<< 16;
   assign ce_q = 63'(energy_ff) <<< 16;

   // pipeline advance
   logic en, rsp_valid_ff;
   assign en = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;

   // s0: request capture
   logic s0_valid_ff;
   logic [REQ_W-1:0] s0_data_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (en) begin
         s0_valid_ff <= req_tvalid;
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         s0_data_ff <= req_tdata;
      end
   end

   // s1: distance fix-up, range test, axis set-up
   logic [RR_W-1:0] rr_raw, rr_fix;
   logic signed [23:0] dr_s;
   logic s1_valid_ff, oor_ff;
   logic [RR_W-1:0] rr_ff;
   word_type dr_ff;

   assign rr_raw = s0_data_ff[166:144];
   assign rr_fix = (rr_raw == '0) ? 23'd1 : rr_raw;
   assign dr_s = $signed({1'b0, rr_fix}) - $signed({1'b0, cutoff_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= s0_valid_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         rr_ff <= rr_fix;
         oor_ff <= active && (rr_fix > cutoff_ff);
         dr_ff <= 63'(dr_s) <<< 16;
      end
   end

   // inverse powers
   logic [INV_NUM_W-1:0] inv_q;
   word_type inv_w, i2, i4, i6, i8, i12, i14, i2_d3, i2_d6, i2_d9, i8_d3, i12_d3, i6_d6;
   word_type slope_inv, slope_inv_d, slope_dr, slope_dr_d;

   lj_div #(.NUM_W(INV_NUM_W), .DEN_W(RR_W), .STEP(DIV_STEP)) u_inv_div (
      .clock(clock), .enable(en), .num(INV_NUM), .den(rr_ff), .quot(inv_q)
   );
   assign inv_w = word_type'({{(WORD_W-INV_NUM_W){1'b0}}, inv_q});

   lj_mul u_mul_i2 (.clock(clock), .enable(en), .a(inv_w), .b(inv_w), .prod(i2));
   lj_mul u_mul_i4 (.clock(clock), .enable(en), .a(i2), .b(i2), .prod(i4));
   lj_delay #(.WIDTH(WORD_W), .DEPTH(ML)) u_i2_d3 (
      .clock(clock), .reset(reset), .enable(en), .din(i2), .dout(i2_d3)
   );
   lj_mul u_mul_i6 (.clock(clock), .enable(en), .a(i2_d3), .b(i4), .prod(i6));
   lj_delay #(.WIDTH(WORD_W), .DEPTH(ML)) u_i2_d6 (
      .clock(clock), .reset(reset), .enable(en), .din(i2_d3), .dout(i2_d6)
   );
   lj_mul u_mul_i8 (.clock(clock), .enable(en), .a(i6), .b(i2_d6), .prod(i8));
   lj_mul u_mul_i12 (.clock(clock), .enable(en), .a(i6), .b(i6), .prod(i12));
   lj_delay #(.WIDTH(WORD_W), .DEPTH(ML)) u_i2_d9 (
      .clock(clock), .reset(reset), .enable(en), .din(i2_d6), .dout(i2_d9)
   );
   lj_mul u_mul_i14 (.clock(clock), .enable(en), .a(i12), .b(i2_d9), .prod(i14));
   lj_delay #(.WIDTH(WORD_W), .DEPTH(ML)) u_i8_d3 (
      .clock(clock), .reset(reset), .enable(en), .din(i8), .dout(i8_d3)
   );
   lj_delay #(.WIDTH(WORD_W), .DEPTH(ML)) u_i12_d3 (
      .clock(clock), .reset(reset), .enable(en), .din(i12), .dout(i12_d3)
   );
   lj_delay #(.WIDTH(WORD_W), .DEPTH(2*ML)) u_i6_d6 (
      .clock(clock), .reset(reset), .enable(en), .din(i6), .dout(i6_d6)
   );

   lj_mul u_mul_sinv (.clock(clock), .enable(en), .a(slope_q), .b(inv_w), .prod(slope_inv));
   lj_delay #(.WIDTH(WORD_W), .DEPTH(4*ML+2)) u_sinv_d (
      .clock(clock), .reset(reset), .enable(en), .din(slope_inv), .dout(slope_inv_d)
   );
   lj_mul u_mul_sdr (.clock(clock), .enable(en), .a(slope_q), .b(dr_ff), .prod(slope_dr));
   lj_delay #(.WIDTH(WORD_W), .DEPTH(LI+4*ML+3)) u_sdr_d (
      .clock(clock), .reset(reset), .enable(en), .din(slope_dr), .dout(slope_dr_d)
   );

   // force scale and energy
   word_type ga_ff, gb_ff, ua_ff, ub_ff, g0_ff, u0_ff, g_ff, u1_ff, u2_ff, u_d;
   always_ff @(posedge clock) begin
      if (en) begin
         ga_ff <= sat_scale(i14, SCALE_48);
         gb_ff <= sat_scale(i8_d3, SCALE_24);
         ua_ff <= sat_scale(i12_d3, SCALE_4);
         ub_ff <= sat_scale(i6_d6, SCALE_4);
         g0_ff <= sat_add(ga_ff, -gb_ff);
         u0_ff <= sat_add(ua_ff, -ub_ff);
         g_ff <= active ? sat_add(g0_ff, slope_inv_d) : g0_ff;
         u1_ff <= active ? sat_add(u0_ff, -ce_q) : u0_ff;
         u2_ff <= active ? sat_add(u1_ff, -slope_dr_d) : u1_ff;
      end
   end
   lj_delay #(.WIDTH(WORD_W), .DEPTH(2*ML+1)) u_u_d (
      .clock(clock), .reset(reset), .enable(en), .din(u2_ff), .dout(u_d)
   );

   // per-axis displacement, force and virial product
   word_type p_q [3];
   word_type f_d [3];

   for (genvar a = 0; a < 3; a++) begin : g_axis
      logic signed [23:0] pa, pb;
      logic signed [24:0] diff;
      logic [24:0] mag_in, mag_ff, mag_dl;
      logic neg_ff, neg_dl, neg_r_ff;
      logic [DISP_NUM_W-1:0] num_ff, n_q;
      logic [48:0] nl_ff;
      logic [49:0] r_wide;
      logic signed [24:0] r_ff;
      word_type r_w, d_ff, d_al, d_al3, f_q;

      assign pa = s0_data_ff[24*a +: 24];
      assign pb = s0_data_ff[72 + 24*a +: 24];
      assign diff = 25'(pa) - 25'(pb);
      assign mag_in = diff[24] ? 25'(-diff) : 25'(diff);

      always_ff @(posedge clock) begin
         if (en) begin
            mag_ff <= mag_in;
            neg_ff <= diff[24];
            num_ff <= 26'({mag_in, 1'b0}) + 26'(len_fix);
         end
      end

      lj_div #(.NUM_W(DISP_NUM_W), .DEN_W(DISP_DEN_W), .STEP(DIV_STEP)) u_div (
         .clock(clock), .enable(en), .num(num_ff), .den({len_fix, 1'b0}), .quot(n_q)
      );
      lj_delay #(.WIDTH(26), .DEPTH(LD+1)) u_mag_d (
         .clock(clock), .reset(reset), .enable(en),
         .din({neg_ff, mag_ff}), .dout({neg_dl, mag_dl})
      );

      assign r_wide = 50'(mag_dl) - 50'(nl_ff);
      assign r_w = 63'(r_ff);

      always_ff @(posedge clock) begin
         if (en) begin
            nl_ff <= 49'(n_q) * 49'(len_fix);
            r_ff <= r_wide[24:0];
            neg_r_ff <= neg_dl;
            d_ff <= (neg_r_ff ? -r_w : r_w) <<< 16;
         end
      end

      lj_delay #(.WIDTH(WORD_W), .DEPTH(LI+5*ML-LD)) u_d_al (
         .clock(clock), .reset(reset), .enable(en), .din(d_ff), .dout(d_al)
      );
      lj_mul u_mul_f (.clock(clock), .enable(en), .a(g_ff), .b(d_al), .prod(f_q));
      lj_delay #(.WIDTH(WORD_W), .DEPTH(ML)) u_d_al3 (
         .clock(clock), .reset(reset), .enable(en), .din(d_al), .dout(d_al3)
      );
      lj_mul u_mul_p (.clock(clock), .enable(en), .a(f_q), .b(d_al3), .prod(p_q[a]));
      lj_delay #(.WIDTH(WORD_W), .DEPTH(ML+2)) u_f_d (
         .clock(clock), .reset(reset), .enable(en), .din(f_q), .dout(f_d[a])
      );
   end

   // virial sum
   word_type s01_ff, p2_ff, vir_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         s01_ff <= sat_add(p_q[0], p_q[1]);
         p2_ff <= p_q[2];
         vir_ff <= sat_add(s01_ff, p2_ff);
      end
   end

   // valid and range flag
   logic v_d, oor_d;
   lj_delay #(.WIDTH(2), .DEPTH(LI+7*ML+5)) u_valid_d (
      .clock(clock), .reset(reset), .enable(en),
      .din({s1_valid_ff, oor_ff}), .dout({v_d, oor_d})
   );

   // output register
   logic [OUT_W-1:0] fo_ff [3];
   logic [OUT_W-1:0] vir_o_ff, en_o_ff;
   logic in_range_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= v_d;
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         in_range_ff <= !oor_d;
         for (int k = 0; k < 3; k++) begin
            fo_ff[k] <= oor_d ? '0 : to_out(f_d[k]);
         end
         vir_o_ff <= oor_d ? '0 : to_out(vir_ff);
         en_o_ff <= oor_d ? '0 : to_out(u_d);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {en_o_ff, vir_o_ff, fo_ff[2], fo_ff[1], fo_ff[0]};
   assign rsp_tuser = in_range_ff;

`include "assert_macros.svh"

   `ASSERT_IMPLIES(a_oor_zero, clock, reset, rsp_tvalid && !rsp_tuser[0], rsp_tdata == '0)
   `ASSERT_IMPLIES(a_oor_cutoff, clock, reset, rsp_tvalid && !rsp_tuser[0], cutoff_ff != '0)
   `ASSERT_NEXT(a_stall_freeze, clock, reset, rsp_tvalid && !rsp_tready, $stable(s1_valid_ff))

endmodule
`default_nettype wire

### hw/rtl/lj_delay.sv
`default_nettype none
module lj_delay #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             enable,
   input  logic [WIDTH-1:0] din,
   output logic [WIDTH-1:0] dout
);
   logic [WIDTH-1:0] tap_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            tap_ff[i] <= '0;
         end
      end else if (enable) begin
         tap_ff[0] <= din;
         for (int i = 1; i < DEPTH; i++) begin
            tap_ff[i] <= tap_ff[i-1];
         end
      end
   end

   assign dout = tap_ff[DEPTH-1];
endmodule
`default_nettype wire

### hw/rtl/lj_div.sv
`default_nettype none
module lj_div #(
   parameter int NUM_W = 49,
   parameter int DEN_W = 23,
   parameter int STEP = 4
) (
   input  logic             clock,
   input  logic             enable,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic [NUM_W-1:0] quot
);
   localparam int STAGES = (NUM_W + STEP - 1) / STEP;
   localparam int PAD_W = STAGES * STEP;

   logic [PAD_W-1:0] num_ff [STAGES];
   logic [PAD_W-1:0] quo_ff [STAGES];
   logic [DEN_W-1:0] rem_ff [STAGES];
   logic [DEN_W-1:0] den_ff [STAGES];

   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      logic [PAD_W-1:0] num_src, quo_src, num_in, quo_in;
      logic [DEN_W-1:0] rem_src, den_src, rem_in;

      if (s == 0) begin : g_first
         assign num_src = PAD_W'(num);
         assign quo_src = '0;
         assign rem_src = '0;
         assign den_src = den;
      end else begin : g_rest
         assign num_src = num_ff[s-1];
         assign quo_src = quo_ff[s-1];
         assign rem_src = rem_ff[s-1];
         assign den_src = den_ff[s-1];
      end

      // restoring steps, one quotient bit each
      always_comb begin
         logic [DEN_W:0] trial;
         num_in = num_src;
         quo_in = quo_src;
         rem_in = rem_src;
         for (int k = 0; k < STEP; k++) begin
            trial = {rem_in, num_in[PAD_W-1]};
            num_in = num_in << 1;
            if (trial >= {1'b0, den_src}) begin
               rem_in = DEN_W'(trial - {1'b0, den_src});
               quo_in = {quo_in[PAD_W-2:0], 1'b1};
            end else begin
               rem_in = trial[DEN_W-1:0];
               quo_in = {quo_in[PAD_W-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            num_ff[s] <= num_in;
            quo_ff[s] <= quo_in;
            rem_ff[s] <= rem_in;
            den_ff[s] <= den_src;
         end
      end
   end

   assign quot = quo_ff[STAGES-1][NUM_W-1:0];
endmodule
`default_nettype wire

### hw/rtl/lj_mul.sv
`default_nettype none
module lj_mul (
   input  logic              clock,
   input  logic              enable,
   input  lj_pkg::word_type  a,
   input  lj_pkg::word_type  b,
   output lj_pkg::word_type  prod
);
   import lj_pkg::*;

   logic [61:0] a_mag_ff, b_mag_ff, a_mag_in, b_mag_in;
   logic neg1_ff, neg2_ff;
   logic [61:0] ll_ff, lh_ff, hl_ff, hh_ff;
   logic [124:0] sum;
   logic [92:0] shifted;
   logic [61:0] mag;
   word_type prod_ff, prod_in;

   assign a_mag_in = a[62] ? 62'(-a) : 62'(a);
   assign b_mag_in = b[62] ? 62'(-b) : 62'(b);

   assign sum = (125'(hh_ff) << 62) + ((125'(lh_ff) + 125'(hl_ff)) << 31) + 125'(ll_ff);
   assign shifted = sum[124:32];
   assign mag = (shifted > 93'(MAG_MAX)) ? MAG_MAX : shifted[61:0];
   assign prod_in = neg2_ff ? -word_type'({1'b0, mag}) : word_type'({1'b0, mag});

   always_ff @(posedge clock) begin
      if (enable) begin
         a_mag_ff <= a_mag_in;
         b_mag_ff <= b_mag_in;
         neg1_ff <= a[62] ^ b[62];
         ll_ff <= 62'(a_mag_ff[30:0]) * 62'(b_mag_ff[30:0]);
         lh_ff <= 62'(a_mag_ff[30:0]) * 62'(b_mag_ff[61:31]);
         hl_ff <= 62'(a_mag_ff[61:31]) * 62'(b_mag_ff[30:0]);
         hh_ff <= 62'(a_mag_ff[61:31]) * 62'(b_mag_ff[61:31]);
         neg2_ff <= neg1_ff;
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;
endmodule
`default_nettype wire

### dv/tb.sv
`default_nettype none
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lj_pkg::*;

   localparam int PIPE_DEPTH = 41;
   localparam int IDLE_LIMIT = 20000;
   localparam logic signed [63:0] CAP = 64'sh3FFF_FFFF_FFFF_FFFF;

   typedef struct packed {
      logic [22:0] pair_dist;
      logic signed [23:0] sz, sy, sx, fz, fy, fx;
   } pair_req_type;

   typedef struct packed {
      logic in_range;
      logic signed [47:0] fx, fy, fz, vir, energy;
   } pair_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic [0:0] rsp_tuser;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [CSR_AW-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   lj_pair_force_energy dut (.*);

   always #2 clock = ~clock;

   // predictor copy of the registers
   logic [22:0] cut_r = 23'd0;
   logic [22:0] cell_len = 23'd655360;
   logic signed [31:0] cut_e = 0, slope_q = 0;

   pair_req_type pending_reqs[$];
   pair_rsp_type expected_forces[$];
   int mismatches = 0, accepted = 0, received = 0, idle_cycles = 0;
   int in_range_seen = 0, out_range_seen = 0;
   bit quiet = 0;   // no idling stretch
   bit hold = 0;
   bit req_fire = 0;

   function automatic logic signed [63:0] clamp(logic signed [64:0] x);
      if (x > 65'(CAP)) return CAP;
      if (x < -65'(CAP)) return -CAP;
      return x[63:0];
   endfunction

   function automatic logic signed [63:0] add_sat(logic signed [63:0] a, logic signed [63:0] b);
      return clamp(65'(clamp(65'(a))) + 65'(clamp(65'(b))));
   endfunction

   function automatic logic signed [63:0] mul_q32(logic signed [63:0] a, logic signed [63:0] b);
      logic [63:0] ma, mb;
      logic [127:0] p;
      logic [63:0] m;
      ma = a < 0 ? -a : a;
      mb = b < 0 ? -b : b;
      p = ma * mb;
      p = p >> 32;
      m = (p > 128'(CAP)) ? CAP : p[63:0];
      return ((a < 0) != (b < 0)) ? -$signed(m) : $signed(m);
   endfunction

   function automatic logic signed [47:0] q32_to_out(logic signed [63:0] q);
      logic [63:0] m;
      m = (q < 0 ? -q : q) >> 8;
      if (q < 0) begin
         if (m > 64'h8000_0000_0000) m = 64'h8000_0000_0000;
         return 48'(-$signed(m));
      end
      if (m > 64'h7FFF_FFFF_FFFF) m = 64'h7FFF_FFFF_FFFF;
      return m[47:0];
   endfunction

   function automatic logic signed [63:0] wrap_disp(logic signed [23:0] a, logic signed [23:0] b,
                                                    logic signed [63:0] len);
      logic signed [63:0] diff, mag, n, rem;
      diff = 64'(a) - 64'(b);
      mag = diff < 0 ? -diff : diff;
      n = (2 * mag + len) / (2 * len);
      rem = mag - n * len;
      return diff < 0 ? -rem : rem;
   endfunction

   function automatic pair_rsp_type lj_pair(pair_req_type q);
      pair_rsp_type o;
      logic signed [63:0] len, rr, inv, i2, i6, i8, i12, i14, g, ur, vir, sl, dr, d, f;
      logic signed [23:0] fa[3], sa[3];
      logic signed [47:0] fo[3];
      bit active;
      fa = '{q.fx, q.fy, q.fz};
      sa = '{q.sx, q.sy, q.sz};
      len = cell_len == 0 ? 1 : 64'(cell_len);
      rr = q.pair_dist == 0 ? 1 : 64'(q.pair_dist);
      active = cut_r != 0;
      o = '{default: '0};
      if (active && rr > 64'(cut_r)) return o;
      inv = (64'sd1 <<< 48) / rr;
      i2 = mul_q32(inv, inv);
      i6 = mul_q32(i2, mul_q32(i2, i2));
      i8 = mul_q32(i6, i2);
      i12 = mul_q32(i6, i6);
      i14 = mul_q32(i12, i2);
      g = add_sat(mul_q32(i14, 64'sd48 <<< 32), -mul_q32(i8, 64'sd24 <<< 32));
      ur = add_sat(mul_q32(i12, 64'sd4 <<< 32), -mul_q32(i6, 64'sd4 <<< 32));
      if (active) begin
         sl = 64'(slope_q) * 65536;
         dr = (rr - 64'(cut_r)) * 65536;
         g = add_sat(g, mul_q32(sl, inv));
         ur = add_sat(ur, -(64'(cut_e) * 65536));
         ur = add_sat(ur, -mul_q32(sl, dr));
      end
      vir = 0;
      for (int k = 0; k < 3; k++) begin
         d = wrap_disp(fa[k], sa[k], len) * 65536;
         f = mul_q32(g, d);
         fo[k] = q32_to_out(f);
         vir = add_sat(vir, mul_q32(f, d));
      end
      o.in_range = 1'b1;
      o.fx = fo[0];
      o.fy = fo[1];
      o.fz = fo[2];
      o.vir = q32_to_out(vir);
      o.energy = q32_to_out(ur);
      return o;
   endfunction

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fire) begin
         if (pending_reqs.size() > 0 && !hold && (quiet || $urandom_range(99) >= 9)) begin
            req_tvalid <= 1'b1;
            req_tdata <= REQ_W'(pending_reqs.pop_front());
         end else begin
            req_tvalid <= 1'b0;
         end
      end
      rsp_tready <= quiet || $urandom_range(99) >= 9;
   end

   // monitor and checker
   always @(posedge clock) begin
      pair_rsp_type got, want;
      req_fire = !reset && req_tvalid && req_tready;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            want = lj_pair(pair_req_type'(req_tdata[166:0]));
            if (want.in_range) in_range_seen++;
            else out_range_seen++;
            expected_forces.push_back(want);
            accepted++;
         end
         if (rsp_tvalid && rsp_tready) begin
            received++;
            got.in_range = rsp_tuser[0];
            {got.energy, got.vir, got.fz, got.fy, got.fx} = rsp_tdata;
            if (expected_forces.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result %h", rsp_tdata);
            end else begin
               want = expected_forces.pop_front();
               if (got != want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: exp %b %h %h %h %h %h got %b %h %h %h %h %h",
                              want.in_range, want.fx, want.fy, want.fz, want.vir,
                              want.energy, got.in_range, got.fx, got.fy, got.fz,
                              got.vir, got.energy);
               end
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no progress");
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   task automatic csr_write(logic [1:0] idx, logic [31:0] val);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_AW'({idx, 2'b00});
      csr_pwdata <= val;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         REG_CUTOFF_RADIUS: cut_r = val[22:0];
         REG_CELL_LENGTH: cell_len = val[22:0];
         REG_CUTOFF_ENERGY: cut_e = val;
         default: slope_q = val;
      endcase
   endtask

   task automatic drain;
      do begin
         @(posedge clock);
         #1;
      end while (pending_reqs.size() != 0 || req_tvalid || expected_forces.size() != 0);
      repeat (PIPE_DEPTH + 5) @(posedge clock);
   endtask

   function automatic logic signed [23:0] rand_pos(int mode);
      if (mode == 0) return $signed(24'($urandom));
      return $signed(24'($urandom_range(1310720))) - 24'sd655360;
   endfunction

   task automatic push_pair(logic signed [23:0] fx, fy, fz, sx, sy, sz, logic [22:0] pair_dist);
      pair_req_type q;
      q = '{pair_dist: pair_dist, sz: sz, sy: sy, sx: sx, fz: fz, fy: fy, fx: fx};
      pending_reqs.push_back(q);
   endtask

   task automatic random_phase(int n, int mode);
      logic [22:0] pair_dist;
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(3))
            0: pair_dist = 23'($urandom);
            1: pair_dist = 23'($urandom_range(40000, 120000));
            2: pair_dist = 23'($urandom_range(0, 70000));
            default: pair_dist = (cut_r != 0) ? cut_r + 23'($urandom_range(2)) - 23'd1
                                              : 23'($urandom_range(65536, 200000));
         endcase
         push_pair(rand_pos(mode), rand_pos(mode), rand_pos(mode),
                   rand_pos(mode), rand_pos(mode), rand_pos(mode), pair_dist);
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed requests at default settings
      push_pair(24'sh7FFFFF, 24'sh800000, 24'sd0, 24'sh800000, 24'sh7FFFFF, 24'sd0, 23'd0);
      push_pair(24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 23'd1);
      push_pair(24'sd327680, -24'sd327680, 24'sd98304, 24'sd0, 24'sd0, 24'sd0, 23'd65536);
      push_pair(24'sd65536, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 23'h7FFFFF);
      push_pair(24'sd73000, 24'sd1, -24'sd1, 24'sd0, 24'sd0, 24'sd0, 23'd73000);
      drain();
      csr_write(REG_CUTOFF_RADIUS, 32'd163840);
      csr_write(REG_CELL_LENGTH, 32'd0);
      csr_write(REG_CUTOFF_ENERGY, 32'hFFFF_F000);
      csr_write(REG_SHIFT_SLOPE, 32'h0000_1234);
      push_pair(24'sd100, -24'sd100, 24'sd7, 24'sd0, 24'sd5, 24'sd0, 23'd163840);
      push_pair(24'sd100, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 23'd163841);
      push_pair(24'sh7FFFFF, 24'sh800000, 24'sd3, 24'sd0, 24'sd0, 24'sd0, 23'd70000);
      drain();
      csr_write(REG_CUTOFF_RADIUS, 32'h007F_FFFF);
      csr_write(REG_CELL_LENGTH, 32'h007F_FFFF);
      csr_write(REG_CUTOFF_ENERGY, 32'h8000_0000);
      csr_write(REG_SHIFT_SLOPE, 32'h7FFF_FFFF);
      push_pair(24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000, 24'sh800000, 24'sh800000,
                24'sh7FFFFF, 23'd1);
      push_pair(24'sd12345, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 23'h7FFFFF);
      drain();

      // random phases over several settings
      quiet = 1;
      csr_write(REG_CUTOFF_RADIUS, 32'd0);
      csr_write(REG_CELL_LENGTH, 32'd655360);
      random_phase(100, 1);
      drain();
      quiet = 0;
      csr_write(REG_CUTOFF_RADIUS, 32'd163840);
      csr_write(REG_CUTOFF_ENERGY, $urandom);
      csr_write(REG_SHIFT_SLOPE, 32'($signed(16'($urandom))));
      random_phase(110, 1);
      drain();
      csr_write(REG_CELL_LENGTH, 32'd1);
      csr_write(REG_SHIFT_SLOPE, 32'h8000_0000);
      random_phase(60, 0);
      // sender holds off until all results are in
      while (pending_reqs.size() > 30) @(posedge clock);
      hold = 1;
      do begin
         @(posedge clock);
         #1;
      end while (req_tvalid || expected_forces.size() != 0);
      hold = 0;
      drain();
      csr_write(REG_CUTOFF_RADIUS, 32'($urandom));
      csr_write(REG_CELL_LENGTH, 32'($urandom));
      csr_write(REG_CUTOFF_ENERGY, $urandom);
      csr_write(REG_SHIFT_SLOPE, $urandom);
      random_phase(90, 0);
      drain();
      csr_write(REG_CUTOFF_RADIUS, 32'd0);
      csr_write(REG_CELL_LENGTH, 32'd300000);
      random_phase(90, 1);
      drain();

      $display("checked %0d requests (%0d within cutoff, %0d beyond) over eight settings",
               accepted, in_range_seen, out_range_seen);
      if (mismatches == 0 && expected_forces.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
`default_nettype wire

### files.f
+incdir+hw/rtl
hw/rtl/lj_pkg.sv
hw/rtl/lj_delay.sv
hw/rtl/lj_div.sv
hw/rtl/lj_mul.sv
hw/rtl/lj_pair_force_energy.sv
dv/tb.sv
